// File: rtl/rrr_pkg.sv
// Shared types for the radical reducer: controller states, multiplier
// operand selects, and the command and status words between controller
// and datapath. No dependencies.
`timescale 1ns / 1ps

package rrr_pkg;

    // Width of the root index field.
    localparam int ROOT_W = 5;

    // Smallest root index the block works with.
    localparam logic [ROOT_W-1:0] ROOT_MIN = 5'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_CMAG_WAIT,
        ST_REST_START,
        ST_REST_WAIT,
        ST_NEXT_D,
        ST_TAIL,
        ST_TAIL_WAIT,
        ST_FINISH
    } state_t;

    // Operand pairs of the shared multiplier.
    typedef enum logic [1:0] {
        MUL_CMAG_D,
        MUL_REST_D,
        MUL_REST_N
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        logic     div_take;
        logic     mul_start;
        logic     mul_wr;
        mul_sel_t mul_sel;
        logic     cnt_dec;
        logic     next_d;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic sq_gt_n;
        logic div_done;
        logic rem_zero;
        logic cnt_last;
        logic cnt_zero;
        logic mul_done;
        logic n_gt_one;
        logic out_free;
    } status_t;

endpackage

// File: rtl/rrr_div.sv
// Restoring divider, one quotient bit per cycle, for trial division.
// Standalone; used by rrr_dpath.
`timescale 1ns / 1ps

module rrr_div #(
    parameter int W  = 32,
    parameter int DW = 17
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [W-1:0]  dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [W-1:0]  quot,
    output logic [DW-1:0] rem
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    // One restoring step: bring down the next dividend bit and try the divisor.
    always_comb begin
        trial = {rem_reg, q_reg[W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = trial >= {1'b0, dvs_reg};
    end

    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = dividend;
            rem_next  = '0;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            q_next   = {q_reg[W-2:0], ge};
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = rem_reg;

endmodule

// File: rtl/rrr_mul.sv
// Shift-and-add multiplier, one bit of b per cycle from the top, whose
// running product saturates at 2^(W-1)+1. Standalone; used by rrr_dpath.
`timescale 1ns / 1ps

module rrr_mul #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic         done,
    output logic [W-1:0] prod
);
    localparam int CW = $clog2(W + 1);
    localparam logic [W-1:0] CAP = {1'b1, {(W-2){1'b0}}, 1'b1};

    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  a_reg;
    logic [W-1:0]  b_reg, b_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W+1:0]  sum;
    logic [W-1:0]  sat;

    // Double the product so far and add a when the current bit of b is set.
    // Once the value reaches the cap it can only grow, so clamping each step
    // gives the clamped final product.
    always_comb begin
        sum = {1'b0, acc_reg, 1'b0} + (b_reg[W-1] ? {2'b00, a_reg} : '0);
        sat = (sum > {2'b00, CAP}) ? CAP : sum[W-1:0];
    end

    always_comb begin
        acc_next  = acc_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next  = '0;
            b_next    = b;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = sat;
            b_next   = {b_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        b_reg   <= b_next;
        if (start) begin
            a_reg <= a;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// File: rtl/rrr_dpath.sv
// Datapath of the radical reducer: working registers, the trial divider,
// the shared multiplier and the result register. Uses rrr_pkg, rrr_div
// and rrr_mul.
`timescale 1ns / 1ps

module rrr_dpath #(
    parameter int W = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rrr_pkg::cmd_t              cmd,
    output rrr_pkg::status_t           status,
    input  logic [W-1:0]               s_coefficient_in,
    input  logic [W-1:0]               s_radicand_in,
    input  logic [rrr_pkg::ROOT_W-1:0] s_root_index,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [W-1:0]               m_coefficient_out,
    output logic [W-2:0]               m_radicand_out,
    output logic                       m_overflow
);
    import rrr_pkg::*;

    // Trial divisors stay at most just above the square root of 2^(W-1).
    localparam int DW = (W + 1) / 2 + 1;
    localparam int SW = 2 * DW;
    localparam logic [W-1:0] LIMIT = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0]      cmag_reg;
    logic [W-1:0]      n_reg;
    logic [W-1:0]      rest_reg;
    logic [DW-1:0]     d_reg;
    logic [SW-1:0]     sq_reg;
    logic [ROOT_W-1:0] cnt_reg;
    logic [ROOT_W-1:0] root_reg;
    logic              neg_reg;

    logic              out_valid_reg, out_valid_next;
    logic [W-1:0]      out_coef_reg;
    logic [W-2:0]      out_rad_reg;
    logic              out_ovf_reg;

    logic              cneg, rneg;
    logic [W-1:0]      cmag_in, rmag_in;
    logic [ROOT_W-1:0] cnt_inc;

    logic              div_done;
    logic [W-1:0]      div_quot;
    logic [DW-1:0]     div_rem;
    logic              mul_done;
    logic [W-1:0]      mul_a, mul_b, mul_prod;

    logic              fin_ovf;
    logic [W-1:0]      fin_cmag;
    logic [W-1:0]      fin_coef;
    logic [W-2:0]      fin_rad;

    // Sign and magnitude of the incoming words; the most negative value
    // wraps to exactly 2^(W-1).
    always_comb begin
        cneg    = s_coefficient_in[W-1];
        rneg    = s_radicand_in[W-1];
        cmag_in = cneg ? (~s_coefficient_in + W'(1)) : s_coefficient_in;
        rmag_in = rneg ? (~s_radicand_in + W'(1)) : s_radicand_in;
        cnt_inc = cnt_reg + ROOT_W'(1);
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (cmd.mul_sel)
            MUL_CMAG_D: begin
                mul_a = cmag_reg;
                mul_b = {{(W-DW){1'b0}}, d_reg};
            end
            MUL_REST_D: begin
                mul_a = rest_reg;
                mul_b = {{(W-DW){1'b0}}, d_reg};
            end
            MUL_REST_N: begin
                mul_a = rest_reg;
                mul_b = n_reg;
            end
            default: begin
                mul_a = rest_reg;
                mul_b = n_reg;
            end
        endcase
    end

    rrr_div #(
        .W  (W),
        .DW (DW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (n_reg),
        .divisor  (d_reg),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    rrr_mul #(
        .W (W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    // Working registers of the factorization.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmag_reg <= cmag_in;
            n_reg    <= rmag_in;
            rest_reg <= (rmag_in[W-1:1] == '0) ? rmag_in : W'(1);
            d_reg    <= DW'(2);
            sq_reg   <= SW'(4);
            cnt_reg  <= '0;
            root_reg <= (s_root_index < ROOT_MIN) ? ROOT_MIN : s_root_index;
            neg_reg  <= cneg ^ rneg;
        end else begin
            if (cmd.div_take) begin
                n_reg   <= div_quot;
                cnt_reg <= (cnt_inc == root_reg) ? '0 : cnt_inc;
            end
            if (cmd.cnt_dec) begin
                cnt_reg <= cnt_reg - ROOT_W'(1);
            end
            if (cmd.mul_wr) begin
                if (cmd.mul_sel == MUL_CMAG_D) begin
                    cmag_reg <= mul_prod;
                end else begin
                    rest_reg <= mul_prod;
                end
            end
            if (cmd.next_d) begin
                d_reg  <= d_reg + DW'(1);
                sq_reg <= sq_reg + {{(SW-DW-1){1'b0}}, d_reg, 1'b1};
            end
        end
    end

    // Sign, saturation and the overflow flag of the finished word.
    always_comb begin
        fin_ovf  = 1'b0;
        fin_cmag = cmag_reg;
        fin_coef = '0;
        if (cmag_reg != '0) begin
            if (neg_reg) begin
                if (cmag_reg > LIMIT) begin
                    fin_ovf  = 1'b1;
                    fin_cmag = LIMIT;
                end
                fin_coef = ~fin_cmag + W'(1);
            end else begin
                if (cmag_reg[W-1]) begin
                    fin_ovf  = 1'b1;
                    fin_cmag = LIMIT - W'(1);
                end
                fin_coef = fin_cmag;
            end
        end
        fin_rad = rest_reg[W-1] ? {(W-1){1'b1}} : rest_reg[W-2:0];
    end

    // Result register: holds a word until the consumer takes it.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_coef_reg <= fin_coef;
            out_rad_reg  <= fin_rad;
            out_ovf_reg  <= fin_ovf;
        end
    end

    // Status back to the controller.
    always_comb begin
        status.sq_gt_n  = sq_reg > {{(SW-W){1'b0}}, n_reg};
        status.div_done = div_done;
        status.rem_zero = div_rem == '0;
        status.cnt_last = cnt_inc == root_reg;
        status.cnt_zero = cnt_reg == '0;
        status.mul_done = mul_done;
        status.n_gt_one = n_reg[W-1:1] != '0;
        status.out_free = !out_valid_reg || m_ready;
    end

    assign m_valid           = out_valid_reg;
    assign m_coefficient_out = out_coef_reg;
    assign m_radicand_out    = out_rad_reg;
    assign m_overflow        = out_ovf_reg;

endmodule

// File: rtl/rrr_ctrl.sv
// Controller of the radical reducer: sequences trial division, power
// extraction and the final product. Uses rrr_pkg.
`timescale 1ns / 1ps

module rrr_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  rrr_pkg::status_t status,
    output rrr_pkg::cmd_t    cmd
);
    import rrr_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = status.sq_gt_n ? ST_TAIL : ST_DIV_WAIT;
            end
            ST_DIV_START: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    if (status.rem_zero) begin
                        state_next = status.cnt_last ? ST_CMAG_WAIT : ST_DIV_START;
                    end else begin
                        state_next = status.cnt_zero ? ST_NEXT_D : ST_REST_START;
                    end
                end
            end
            ST_CMAG_WAIT: begin
                if (status.mul_done) begin
                    state_next = ST_DIV_START;
                end
            end
            ST_REST_START: begin
                state_next = ST_REST_WAIT;
            end
            ST_REST_WAIT: begin
                if (status.mul_done) begin
                    state_next = status.cnt_zero ? ST_NEXT_D : ST_REST_START;
                end
            end
            ST_NEXT_D: begin
                state_next = ST_CHECK;
            end
            ST_TAIL: begin
                state_next = status.n_gt_one ? ST_TAIL_WAIT : ST_FINISH;
            end
            ST_TAIL_WAIT: begin
                if (status.mul_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        cmd         = '0;
        cmd.mul_sel = MUL_REST_D;
        s_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_CHECK: begin
                cmd.div_start = !status.sq_gt_n;
            end
            ST_DIV_START: begin
                cmd.div_start = 1'b1;
            end
            ST_DIV_WAIT: begin
                // A full power of the divisor moves into the coefficient.
                cmd.mul_sel = MUL_CMAG_D;
                if (status.div_done && status.rem_zero) begin
                    cmd.div_take  = 1'b1;
                    cmd.mul_start = status.cnt_last;
                end
            end
            ST_CMAG_WAIT: begin
                cmd.mul_sel = MUL_CMAG_D;
                cmd.mul_wr  = status.mul_done;
            end
            ST_REST_START: begin
                cmd.mul_sel   = MUL_REST_D;
                cmd.mul_start = 1'b1;
                cmd.cnt_dec   = 1'b1;
            end
            ST_REST_WAIT: begin
                cmd.mul_sel = MUL_REST_D;
                cmd.mul_wr  = status.mul_done;
            end
            ST_NEXT_D: begin
                cmd.next_d = 1'b1;
            end
            ST_TAIL: begin
                cmd.mul_sel   = MUL_REST_N;
                cmd.mul_start = status.n_gt_one;
            end
            ST_TAIL_WAIT: begin
                cmd.mul_sel = MUL_REST_N;
                cmd.mul_wr  = status.mul_done;
            end
            ST_FINISH: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // The divider and the multiplier are never started together.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.div_start && cmd.mul_start))
        else $error("divider and multiplier started in the same cycle");

    // A division finishes only while the controller waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> state_reg == ST_DIV_WAIT)
        else $error("division finished outside its wait state");

    // A product finishes only while the controller waits for one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.mul_done |-> (state_reg == ST_CMAG_WAIT || state_reg == ST_REST_WAIT ||
                             state_reg == ST_TAIL_WAIT))
        else $error("product finished outside a wait state");

    // A word is loaded into the result register only when it is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result register overwritten while still held");

    // After a new item is taken, the first step is the divisor check.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_CHECK)
        else $error("item taken without starting the divisor check");

endmodule

// File: rtl/nth_root_radical_reducer.sv
// Top level of the nth-root radical reducer: controller plus datapath.
// Uses rrr_pkg, rrr_ctrl and rrr_dpath.
//
//   Channel   Handshake           Word
//   s_        s_valid / s_ready   s_coefficient_in, s_radicand_in, s_root_index
//   m_        m_valid / m_ready   m_coefficient_out, m_radicand_out, m_overflow
//
// An item runs a trial division for every divisor from 2 up to the square root
// of what remains of the radicand, another division for every division that
// leaves no remainder, and a multiplication for every product formed, besides
// the steps to load and finish.
// The bit-serial trial divider and the shift-and-add multiplier do this work.
// One item is worked on at a time; a new word is taken while the last result
// still waits in the output register.
// Reset is synchronous and active low and empties the block.
// A stalled m_ready holds the result and, once the next item is done, s_ready.
`timescale 1ns / 1ps

module nth_root_radical_reducer #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [VALUE_WIDTH-1:0]     s_coefficient_in,
    input  logic [VALUE_WIDTH-1:0]     s_radicand_in,
    input  logic [rrr_pkg::ROOT_W-1:0] s_root_index,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [VALUE_WIDTH-1:0]     m_coefficient_out,
    output logic [VALUE_WIDTH-2:0]     m_radicand_out,
    output logic                       m_overflow
);
    import rrr_pkg::*;

    cmd_t    cmd;
    status_t status;

    rrr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rrr_dpath #(
        .W (VALUE_WIDTH)
    ) u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_coefficient_in  (s_coefficient_in),
        .s_radicand_in     (s_radicand_in),
        .s_root_index      (s_root_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_coefficient_out (m_coefficient_out),
        .m_radicand_out    (m_radicand_out),
        .m_overflow        (m_overflow)
    );

endmodule

// File: bench/nrr_form_checker.sv
// Result checker for the radical reducer: predicts the reduced form of every
// accepted input word and compares it with the words leaving the block.
// Depends on rrr_pkg for the root index width.
`timescale 1ns / 1ps

module nrr_form_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [31:0]                s_coefficient_in,
    input  logic [31:0]                s_radicand_in,
    input  logic [rrr_pkg::ROOT_W-1:0] s_root_index,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [31:0]                m_coefficient_out,
    input  logic [30:0]                m_radicand_out,
    input  logic                       m_overflow,
    output int                         fail_count,
    output int                         pending
);

    localparam logic [63:0] MAG_HALF = 64'h0000_0000_8000_0000;
    localparam logic [63:0] MAG_CAP  = 64'h0000_0000_8000_0001;

    typedef struct packed {
        logic [31:0] coefficient;
        logic [30:0] radicand;
        logic        overflow;
    } radical_t;

    radical_t awaited_forms [$];
    int       mismatches = 0;

    // Multiply a coefficient magnitude, clamping just above the signed range.
    function automatic logic [63:0] scale_mag(logic [63:0] mag, logic [63:0] f);
        logic [63:0] prod;
        if (mag == 0 || f == 0) begin
            return 64'd0;
        end
        if (mag > MAG_CAP / f) begin
            return MAG_CAP;
        end
        prod = mag * f;
        return (prod > MAG_CAP) ? MAG_CAP : prod;
    endfunction

    // Reduce coefficient * root-th-root(radicand) to simplest radical form.
    function automatic radical_t reduce_radical(logic [31:0] coef_word,
                                                logic [31:0] rad_word,
                                                logic [rrr_pkg::ROOT_W-1:0] root_word);
        logic [63:0] cmag, n, rest, d, neg_mag;
        logic        cneg, rneg, sat;
        int unsigned root, m, k;
        radical_t    r;
        cneg = coef_word[31];
        rneg = rad_word[31];
        cmag = cneg ? (64'h1_0000_0000 - {32'b0, coef_word}) : {32'b0, coef_word};
        n    = rneg ? (64'h1_0000_0000 - {32'b0, rad_word}) : {32'b0, rad_word};
        root = root_word;
        if (root < 2) begin
            root = 2;
        end
        sat = 1'b0;

        // Trial division; stop once the divisor squared passes what remains.
        if (n < 2) begin
            rest = n;
        end else begin
            rest = 64'd1;
            d = 64'd2;
            while (d <= n / d) begin
                m = 0;
                while (n % d == 0) begin
                    n = n / d;
                    m++;
                end
                for (k = 0; k < m / root; k++) begin
                    cmag = scale_mag(cmag, d);
                end
                for (k = 0; k < m % root; k++) begin
                    rest = rest * d;
                end
                d++;
            end
            if (n > 1) begin
                rest = rest * n;
            end
        end

        // Apply the sign and saturate to the signed coefficient range.
        if (cmag == 0) begin
            r.coefficient = 32'd0;
        end else if (cneg != rneg) begin
            if (cmag > MAG_HALF) begin
                sat = 1'b1;
                cmag = MAG_HALF;
            end
            neg_mag = ~cmag + 64'd1;
            r.coefficient = neg_mag[31:0];
        end else begin
            if (cmag > MAG_HALF - 1) begin
                sat = 1'b1;
                cmag = MAG_HALF - 1;
            end
            r.coefficient = cmag[31:0];
        end
        if (rest > MAG_HALF - 1) begin
            rest = MAG_HALF - 1;
        end
        r.radicand = rest[30:0];
        r.overflow = sat;
        return r;
    endfunction

    // Queue a prediction per accepted input word; check each result word.
    always @(posedge aclk) begin
        radical_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                awaited_forms = {awaited_forms,
                                 reduce_radical(s_coefficient_in, s_radicand_in,
                                                s_root_index)};
            end
            if (m_valid && m_ready) begin
                if (awaited_forms.size() == 0) begin
                    $error("result word with no input word waiting: coefficient %0d",
                           $signed(m_coefficient_out));
                    mismatches++;
                end else begin
                    want = awaited_forms.pop_front();
                    if (m_coefficient_out !== want.coefficient) begin
                        $error("coefficient_out: expected %0d, actual %0d",
                               $signed(want.coefficient), $signed(m_coefficient_out));
                        mismatches++;
                    end
                    if (m_radicand_out !== want.radicand) begin
                        $error("radicand_out: expected %0d, actual %0d",
                               want.radicand, m_radicand_out);
                        mismatches++;
                    end
                    if (m_overflow !== want.overflow) begin
                        $error("overflow: expected %0d, actual %0d",
                               want.overflow, m_overflow);
                        mismatches++;
                    end
                end
            end
            fail_count <= mismatches;
            pending    <= awaited_forms.size();
        end
    end

endmodule

// File: bench/tb_nth_root_radical_reducer.sv
// Testbench top for nth_root_radical_reducer: clock, reset, directed and
// random input words, random stalls on both channels, and the verdict.
// Depends on rrr_pkg, the block itself and nrr_form_checker.
`timescale 1ns / 1ps

module tb_nth_root_radical_reducer;

    import rrr_pkg::*;

    localparam int          ROOT_MAX    = (1 << ROOT_W) - 1;
    localparam logic [63:0] RAD_MAX     = 64'h0000_0000_7FFF_FFFF;
    // The limit is many times the slowest correct run, stalls included.
    localparam int          CYCLE_LIMIT = 6_000_000;
    localparam int          DRAIN_CYCLES = 64;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [31:0]       s_coefficient_in;
    logic [31:0]       s_radicand_in;
    logic [ROOT_W-1:0] s_root_index;
    logic              m_valid;
    logic              m_ready;
    logic [31:0]       m_coefficient_out;
    logic [30:0]       m_radicand_out;
    logic              m_overflow;
    int                fail_count;
    int                pending;
    logic              quiet = 1'b0;
    int                cycles = 0;
    int unsigned       small_primes [0:10] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31};

    nth_root_radical_reducer #(
        .VALUE_WIDTH(32)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_coefficient_in  (s_coefficient_in),
        .s_radicand_in     (s_radicand_in),
        .s_root_index      (s_root_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_coefficient_out (m_coefficient_out),
        .m_radicand_out    (m_radicand_out),
        .m_overflow        (m_overflow)
    );

    nrr_form_checker form_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_coefficient_in  (s_coefficient_in),
        .s_radicand_in     (s_radicand_in),
        .s_root_index      (s_root_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_coefficient_out (m_coefficient_out),
        .m_radicand_out    (m_radicand_out),
        .m_overflow        (m_overflow),
        .fail_count        (fail_count),
        .pending           (pending)
    );

    // Free-running clock, 10 ns period.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("nth_root_radical_reducer: mismatch");
        $finish;
    end

    // Receiver: random stall bursts until the quiet phase.
    initial begin
        m_ready = 1'b1;
        forever begin
            @(negedge aclk);
            if (!quiet && aresetn && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // Present one word at a falling edge and hold it until it is taken.
    task automatic send_word(input logic [31:0] coef, input logic [31:0] rad,
                             input logic [ROOT_W-1:0] root);
        s_valid          <= 1'b1;
        s_coefficient_in <= coef;
        s_radicand_in    <= rad;
        s_root_index     <= root;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Drop valid for a random burst.
    task automatic sender_gap();
        s_valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge aclk);
    endtask

    // Hold the sender back until every predicted word has come out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
    endtask

    // Radicands: mostly small values or products of small prime powers, with
    // exponents scaled to the root so that powers get extracted. A cofactor
    // up to 1000 keeps the trial division short.
    function automatic logic [31:0] pick_radicand(int unsigned root);
        logic [63:0] val, neg_val;
        int unsigned p, e;
        if ($urandom_range(0, 9) < 4) begin
            val = $urandom_range(0, 1023);
        end else begin
            val = 64'd1;
            repeat ($urandom_range(1, 4)) begin
                p = small_primes[$urandom_range(0, 10)];
                e = $urandom_range(1, 3 * root);
                repeat (e) begin
                    if (val * p <= RAD_MAX) begin
                        val = val * p;
                    end
                end
            end
            if ($urandom_range(0, 1) == 1) begin
                e = $urandom_range(2, 1000);
                if (val * e <= RAD_MAX) begin
                    val = val * e;
                end
            end
        end
        neg_val = 64'h1_0000_0000 - val;
        return ($urandom_range(0, 1) == 1) ? neg_val[31:0] : val[31:0];
    endfunction

    // Coefficients: full-range random, small, extreme, or moderate.
    function automatic logic [31:0] pick_coefficient();
        logic [31:0] mag;
        case ($urandom_range(0, 5))
            0: begin
                return $urandom;
            end
            1: begin
                return $urandom_range(0, 200) - 100;
            end
            2: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'd0;
                    3:       return 32'd1;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: begin
                mag = $urandom_range(0, 65535);
                return ($urandom_range(0, 1) == 1) ? -mag : mag;
            end
        endcase
    endfunction

    // Random words, small roots favored, with sender gaps unless quiet.
    task automatic random_phase(input int count);
        int unsigned root;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 2) != 0) begin
                root = $urandom_range(ROOT_MIN, 5);
            end else begin
                root = $urandom_range(ROOT_MIN, ROOT_MAX);
            end
            send_word(pick_coefficient(), pick_radicand(root), root[ROOT_W-1:0]);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                sender_gap();
            end
        end
    endtask

    // Main sequence: reset, directed words, random phases, verdict.
    initial begin
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_coefficient_in = 32'd0;
        s_radicand_in    = 32'd0;
        s_root_index     = ROOT_MIN;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Zero and one radicands pass through; a negative one flips the sign.
        send_word(32'd1, 32'd0, 5'd2);
        send_word(32'd5, 32'd1, 5'd3);
        send_word(-32'sd7, -32'sd1, 5'd2);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
        // Plain extractions, odd and even roots on negative radicands.
        send_word(32'd1, 32'd72, 5'd2);
        sender_gap();
        send_word(32'd3, -32'sd8, 5'd3);
        send_word(32'd2, -32'sd16, 5'd2);
        send_word(32'd0, 32'd64, 5'd2);
        send_word(32'd12, 32'd291600, 5'd2);
        send_word(32'd12, 32'd291600, 5'd3);
        // Coefficient saturation, both signs, and the most negative value.
        send_word(32'h7FFF_FFFF, 32'd4, 5'd2);
        send_word(32'h8000_0000, 32'd4, 5'd2);
        send_word(32'h8000_0000, 32'd1, 5'd2);
        send_word(32'h8000_0000, -32'sd1, 5'd5);
        send_word(32'd1000000, 32'd1000000000, 5'd3);
        send_word(32'd1000000, 32'd1000000000, 5'd2);
        sender_gap();
        // Most negative radicand, large radicands, root at its ends.
        send_word(32'd1, 32'h8000_0000, 5'd31);
        send_word(32'd1, 32'h8000_0000, 5'd2);
        send_word(-32'sd1, 32'd2147483646, 5'd2);
        send_word(32'd1, 32'd1073741824, 5'd30);
        send_word(32'd1, 32'd1162261467, 5'd31);
        send_word(32'd9, 32'd997, 5'd2);
        // Root index below two behaves as a square root.
        send_word(32'd3, 32'd50, 5'd0);
        send_word(32'd3, 32'd50, 5'd1);
        wait_drained();

        // Random words with stalls, a full pause in the middle.
        random_phase(120);
        wait_drained();
        random_phase(107);

        // Last stretch runs without idling on either side.
        quiet <= 1'b1;
        random_phase(40);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("nth_root_radical_reducer: match");
        end else begin
            $display("nth_root_radical_reducer: mismatch");
        end
        $finish;
    end

endmodule
